@@ hdl/wireframe_box_voxel_animator_macros.svh @@
// ----------------------------------------------------------------------------
// Wireframe box voxel animator: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef WIREFRAME_BOX_VOXEL_ANIMATOR_MACROS_SVH
`define WIREFRAME_BOX_VOXEL_ANIMATOR_MACROS_SVH

// Assertion that is ignored while reset is held.
`define WBVA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is also checked during reset.
`define WBVA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/wbva_pkg.sv @@
// ----------------------------------------------------------------------------
// Wireframe box voxel animator: package
// Constants, control word layout and the microprogram ROM.
// ----------------------------------------------------------------------------
package wbva_pkg;

  // Cube geometry
  localparam int CUBE_SIDE   = 8;
  localparam int CW          = (CUBE_SIDE > 1) ? $clog2(CUBE_SIDE) : 1;
  localparam int MASK_W      = 8;
  localparam int COORD_W     = 3;
  localparam int COLOR_TRIES = 10;
  localparam int TRY_W       = $clog2(COLOR_TRIES + 2);

  // LCG constants
  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_INC = 32'd1013904223;

  // Color digit ranges
  localparam logic [7:0] HI_BASE  = 8'd200;
  localparam logic [7:0] MID_BASE = 8'd80;
  localparam logic [6:0] HI_DIV   = 7'd56;
  localparam logic [6:0] MID_DIV  = 7'd121;
  localparam logic [6:0] LO_DIV   = 7'd41;
  localparam logic [6:0] SEL_DIV  = 7'd6;
  localparam logic [23:0] WHITE   = 24'hFFFFFF;

  // Reciprocals for the byte remainders, rounded down (quotient off by at most one)
  localparam logic [15:0] HI_RECIP  = 16'(65536 / 56);
  localparam logic [15:0] MID_RECIP = 16'(65536 / 121);
  localparam logic [15:0] LO_RECIP  = 16'(65536 / 41);
  localparam logic [15:0] SEL_RECIP = 16'(65536 / 6);

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_INIT,
    OP_STEP,
    OP_QUOT,
    OP_REM,
    OP_PICK,
    OP_ROW,
    OP_UPDATE,
    OP_NEWCORNER
  } op_t;

  // Sequencer next-address modes
  typedef enum logic [2:0] {
    J_NEXT,
    J_GOTO,
    J_WAIT,
    J_RETRY,
    J_DRAWRET,
    J_ROWS,
    J_WRAP
  } jmp_t;

  // Which color digit a step works on
  typedef enum logic [1:0] {
    DIG_HI,
    DIG_MID,
    DIG_LO,
    DIG_SEL
  } dig_t;

  localparam int PC_W = 5;
  typedef logic [PC_W-1:0] addr_t;

  // Microprogram addresses
  localparam addr_t A_IDLE    = 5'd0;
  localparam addr_t A_INIT    = 5'd1;
  localparam addr_t A_HI      = 5'd2;
  localparam addr_t A_MID     = 5'd5;
  localparam addr_t A_LO      = 5'd8;
  localparam addr_t A_SEL     = 5'd11;
  localparam addr_t A_PICK    = 5'd14;
  localparam addr_t A_DRAWRET = 5'd15;
  localparam addr_t A_RENDER  = 5'd16;
  localparam addr_t A_UPDATE  = 5'd17;
  localparam addr_t A_NEWC    = 5'd18;

  typedef struct packed {
    op_t   op;
    jmp_t  jmp;
    dig_t  dig;
    addr_t target;
  } ctrl_word_t;

  // Status fed back to the sequencer
  typedef struct packed {
    logic in_go;
    logic started;
    logic pick_ok;
    logic post;
    logic last_row;
    logic wrap;
  } wbva_stat_t;

  // Microprogram
  function automatic ctrl_word_t rom_word(addr_t addr);
    ctrl_word_t w;
    w = '{op: OP_NOP, jmp: J_GOTO, dig: DIG_HI, target: A_IDLE};
    unique case (addr)
      A_IDLE:      w = '{op: OP_NOP,       jmp: J_WAIT,    dig: DIG_HI,  target: A_INIT};
      A_INIT:      w = '{op: OP_INIT,      jmp: J_NEXT,    dig: DIG_HI,  target: A_HI};
      A_HI:        w = '{op: OP_STEP,      jmp: J_NEXT,    dig: DIG_HI,  target: A_IDLE};
      A_HI + 1:    w = '{op: OP_QUOT,      jmp: J_NEXT,    dig: DIG_HI,  target: A_IDLE};
      A_HI + 2:    w = '{op: OP_REM,       jmp: J_NEXT,    dig: DIG_HI,  target: A_IDLE};
      A_MID:       w = '{op: OP_STEP,      jmp: J_NEXT,    dig: DIG_MID, target: A_IDLE};
      A_MID + 1:   w = '{op: OP_QUOT,      jmp: J_NEXT,    dig: DIG_MID, target: A_IDLE};
      A_MID + 2:   w = '{op: OP_REM,       jmp: J_NEXT,    dig: DIG_MID, target: A_IDLE};
      A_LO:        w = '{op: OP_STEP,      jmp: J_NEXT,    dig: DIG_LO,  target: A_IDLE};
      A_LO + 1:    w = '{op: OP_QUOT,      jmp: J_NEXT,    dig: DIG_LO,  target: A_IDLE};
      A_LO + 2:    w = '{op: OP_REM,       jmp: J_NEXT,    dig: DIG_LO,  target: A_IDLE};
      A_SEL:       w = '{op: OP_STEP,      jmp: J_NEXT,    dig: DIG_SEL, target: A_IDLE};
      A_SEL + 1:   w = '{op: OP_QUOT,      jmp: J_NEXT,    dig: DIG_SEL, target: A_IDLE};
      A_SEL + 2:   w = '{op: OP_REM,       jmp: J_NEXT,    dig: DIG_SEL, target: A_IDLE};
      A_PICK:      w = '{op: OP_PICK,      jmp: J_RETRY,   dig: DIG_HI,  target: A_HI};
      A_DRAWRET:   w = '{op: OP_NOP,       jmp: J_DRAWRET, dig: DIG_HI,  target: A_IDLE};
      A_RENDER:    w = '{op: OP_ROW,       jmp: J_ROWS,    dig: DIG_HI,  target: A_IDLE};
      A_UPDATE:    w = '{op: OP_UPDATE,    jmp: J_WRAP,    dig: DIG_HI,  target: A_IDLE};
      A_NEWC:      w = '{op: OP_NEWCORNER, jmp: J_GOTO,    dig: DIG_HI,  target: A_HI};
      default:     w = '{op: OP_NOP,       jmp: J_GOTO,    dig: DIG_HI,  target: A_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ hdl/wireframe_box_voxel_animator.sv @@
// ----------------------------------------------------------------------------
// Wireframe box voxel animator: top level
// Renders an 8x8x8 wireframe box frame as 64 voxel rows for each tick with in_tick set.
// ----------------------------------------------------------------------------
// Each accepted tick with in_tick set produces 64 row transactions (x outer,
// y inner), one per cycle while out_stall is low, from a single output
// register; a tick with in_tick clear is consumed and produces nothing. An
// ordinary frame runs the 64 rows, a span update and the return to idle
// before the next tick can be taken. The very first tick and every frame
// that ends a grow phase also run a color draw on the shared LCG and
// reciprocal-remainder datapath: 1 to 11 tries, each stepping the LCG and
// taking a remainder for the hi, mid, lo and sel digits before the pick,
// plus a setup step before and a return step after. The seed register may
// be written at any time but is only loaded on the first tick after reset.
module wireframe_box_voxel_animator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_tick,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_row_x,
  output logic [2:0]  out_row_y,
  output logic [7:0]  out_lit_mask,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_frame_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_seed
);
  import wbva_pkg::*;

  ctrl_word_t  ctrl;
  wbva_stat_t  stat;
  logic        idle;
  logic [23:0] edge_color;
  logic        pick_ok, post, started, last_row, wrap;

  assign in_stall  = !idle;
  assign cfg_ready = 1'b1;

  // Status back to the sequencer
  assign stat = '{in_go:    in_valid && idle && in_tick,
                  started:  started,
                  pick_ok:  pick_ok,
                  post:     post,
                  last_row: last_row,
                  wrap:     wrap};

  wbva_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl),
    .idle  (idle)
  );

  wbva_color u_color (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .cfg_valid  (cfg_valid),
    .cfg_seed   (cfg_seed),
    .edge_color (edge_color),
    .pick_ok    (pick_ok),
    .post       (post)
  );

  wbva_frame u_frame (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .edge_color    (edge_color),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_row_x     (out_row_x),
    .out_row_y     (out_row_y),
    .out_lit_mask  (out_lit_mask),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_frame_end (out_frame_end),
    .started       (started),
    .last_row      (last_row),
    .wrap          (wrap)
  );

endmodule

@@ hdl/wbva_seq.sv @@
// ----------------------------------------------------------------------------
// Wireframe box voxel animator: microsequencer
// Step counter over the microprogram ROM with conditional jumps.
// ----------------------------------------------------------------------------
module wbva_seq (
  input  logic                    clk,
  input  logic                    rst_n,
  input  wbva_pkg::wbva_stat_t    stat,
  output wbva_pkg::ctrl_word_t    ctrl,
  output logic                    idle
);
  import wbva_pkg::*;

  addr_t pc_r;
  addr_t pc_nxt;

  assign ctrl = rom_word(pc_r);
  assign idle = (pc_r == A_IDLE);

  // Next step address
  always_comb begin
    pc_nxt = pc_r;
    unique case (ctrl.jmp)
      J_NEXT:    pc_nxt = pc_r + 1'b1;
      J_GOTO:    pc_nxt = ctrl.target;
      J_WAIT:    if (stat.in_go) pc_nxt = stat.started ? A_RENDER : ctrl.target;
      J_RETRY:   pc_nxt = stat.pick_ok ? pc_r + 1'b1 : ctrl.target;
      J_DRAWRET: pc_nxt = stat.post ? A_IDLE : pc_r + 1'b1;
      J_ROWS:    pc_nxt = stat.last_row ? pc_r + 1'b1 : pc_r;
      J_WRAP:    pc_nxt = stat.wrap ? pc_r + 1'b1 : A_IDLE;
      default:   pc_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= A_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

@@ hdl/wbva_color.sv @@
// ----------------------------------------------------------------------------
// Wireframe box voxel animator: color unit
// LCG, byte remainders by reciprocal multiply, and the distinct-color pick.
// ----------------------------------------------------------------------------
module wbva_color (
  input  logic                  clk,
  input  logic                  rst_n,
  input  wbva_pkg::ctrl_word_t  ctrl,
  input  logic                  cfg_valid,
  input  logic [31:0]           cfg_seed,
  output logic [23:0]           edge_color,
  output logic                  pick_ok,
  output logic                  post
);
  import wbva_pkg::*;

  // Channel order codes drawn by the sel digit
  localparam logic [2:0] ORD_HML = 3'd0;
  localparam logic [2:0] ORD_HLM = 3'd1;
  localparam logic [2:0] ORD_MHL = 3'd2;
  localparam logic [2:0] ORD_LHM = 3'd3;
  localparam logic [2:0] ORD_MLH = 3'd4;

  logic [31:0]      seed_r;
  logic [31:0]      lcg_r;
  logic [5:0]       q_r;
  logic [7:0]       hi_r, mid_r, lo_r;
  logic [2:0]       sel_r;
  logic [TRY_W-1:0] try_r;
  logic [23:0]      edge_r, prev_r;
  logic             post_r;

  logic [7:0]       rnd_byte;
  logic [15:0]      recip;
  logic [6:0]       divisor;
  logic [7:0]       base;
  logic [23:0]      qprod;
  logic [12:0]      qd;
  logic [8:0]       rem0, rem1;
  logic [7:0]       digit;
  logic [23:0]      color;
  logic [TRY_W-1:0] try_inc;

  assign rnd_byte = lcg_r[31:24];

  // Per-digit constants
  always_comb begin
    unique case (ctrl.dig)
      DIG_HI:  begin recip = HI_RECIP;  divisor = HI_DIV;  base = HI_BASE;  end
      DIG_MID: begin recip = MID_RECIP; divisor = MID_DIV; base = MID_BASE; end
      DIG_LO:  begin recip = LO_RECIP;  divisor = LO_DIV;  base = '0;       end
      default: begin recip = SEL_RECIP; divisor = SEL_DIV; base = '0;       end
    endcase
  end

  // Quotient estimate, then remainder with one correction
  assign qprod = 24'(rnd_byte) * 24'(recip);
  assign qd    = 13'(q_r) * 13'(divisor);
  assign rem0  = {1'b0, rnd_byte} - qd[8:0];
  assign rem1  = (rem0 >= 9'(divisor)) ? rem0 - 9'(divisor) : rem0;
  assign digit = rem1[7:0] + base;

  // Channel order
  always_comb begin
    case (sel_r)
      ORD_HML: color = {hi_r,  mid_r, lo_r};
      ORD_HLM: color = {hi_r,  lo_r,  mid_r};
      ORD_MHL: color = {mid_r, hi_r,  lo_r};
      ORD_LHM: color = {lo_r,  hi_r,  mid_r};
      ORD_MLH: color = {mid_r, lo_r,  hi_r};
      default: color = {lo_r,  mid_r, hi_r};
    endcase
  end

  // Take the draw if it differs, or if the tries are used up
  assign try_inc = try_r + 1'b1;
  assign pick_ok = (color != prev_r) || (try_inc == TRY_W'(COLOR_TRIES + 1));

  assign edge_color = edge_r;
  assign post       = post_r;

  // Seed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_valid) begin
      seed_r <= cfg_seed;
    end
  end

  // Draw control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      post_r <= 1'b0;
      try_r  <= '0;
    end else begin
      case (ctrl.op)
        OP_INIT:      begin post_r <= 1'b0; try_r <= '0; end
        OP_NEWCORNER: begin post_r <= 1'b1; try_r <= '0; end
        OP_PICK:      try_r <= try_inc;
        default:      ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_INIT: begin
        lcg_r  <= seed_r;
        prev_r <= WHITE;
      end
      OP_STEP: lcg_r <= lcg_r * LCG_MUL + LCG_INC;
      OP_QUOT: q_r <= qprod[21:16];
      OP_REM: begin
        case (ctrl.dig)
          DIG_HI:  hi_r  <= digit;
          DIG_MID: mid_r <= digit;
          DIG_LO:  lo_r  <= digit;
          default: sel_r <= digit[2:0];
        endcase
      end
      OP_PICK:      if (pick_ok) edge_r <= color;
      OP_NEWCORNER: prev_r <= edge_r;
      default:      ;
    endcase
  end

endmodule

@@ hdl/wbva_frame.sv @@
// ----------------------------------------------------------------------------
// Wireframe box voxel animator: frame unit
// Box state, row scan, edge mask and the output register.
// ----------------------------------------------------------------------------
module wbva_frame (
  input  logic                  clk,
  input  logic                  rst_n,
  input  wbva_pkg::ctrl_word_t  ctrl,
  input  logic [23:0]           edge_color,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [2:0]            out_row_x,
  output logic [2:0]            out_row_y,
  output logic [7:0]            out_lit_mask,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  output logic                  out_frame_end,
  output logic                  started,
  output logic                  last_row,
  output logic                  wrap
);
  import wbva_pkg::*;

  localparam logic [CW-1:0] CMAX = CW'(CUBE_SIDE - 1);

  logic          started_r;
  logic [CW-1:0] span_r, span_nxt;
  logic          growing_r, growing_nxt;
  logic [2:0]    corner_r;
  logic [CW-1:0] x_r, y_r;

  logic              out_valid_r;
  logic [COORD_W-1:0] row_x_r, row_y_r;
  logic [MASK_W-1:0]  mask_r;
  logic [23:0]        rgb_r;
  logic               end_r;

  logic          hx, hy, hz;
  logic [CW-1:0] x0, x1, y0, y1, z0, z1;
  logic          in_xy, ex, ey;
  logic [MASK_W-1:0] mask;
  logic          load, row_last;
  logic [CW-1:0] dec;
  logic [CW:0]   inc;

  // Box bounds from corner and span
  assign hx = (corner_r[1:0] == 2'd1) || (corner_r[1:0] == 2'd2);
  assign hy = (corner_r[1:0] == 2'd2) || (corner_r[1:0] == 2'd3);
  assign hz = corner_r[2];
  assign x0 = hx ? CMAX - span_r : '0;
  assign x1 = hx ? CMAX : span_r;
  assign y0 = hy ? CMAX - span_r : '0;
  assign y1 = hy ? CMAX : span_r;
  assign z0 = hz ? CMAX - span_r : '0;
  assign z1 = hz ? CMAX : span_r;

  assign in_xy = (x_r >= x0) && (x_r <= x1) && (y_r >= y0) && (y_r <= y1);
  assign ex    = (x_r == x0) || (x_r == x1);
  assign ey    = (y_r == y0) || (y_r == y1);

  // Lit when at least two of the three coordinates sit on the boundary
  always_comb begin
    logic ez;
    mask = '0;
    for (int z = 0; z < CUBE_SIDE; z++) begin
      ez = (CW'(z) == z0) || (CW'(z) == z1);
      if (in_xy && (CW'(z) >= z0) && (CW'(z) <= z1)) begin
        mask[z] = (ex && ey) || (ex && ez) || (ey && ez);
      end
    end
  end

  assign load     = (ctrl.op == OP_ROW) && (!out_valid_r || !out_stall);
  assign row_last = (x_r == CMAX) && (y_r == CMAX);
  assign last_row = load && row_last;

  // Span step between frames
  assign inc  = {1'b0, span_r} + 1'b1;
  assign dec  = (span_r != '0) ? span_r - 1'b1 : '0;
  assign wrap = growing_r && (inc >= {1'b0, CMAX});

  always_comb begin
    span_nxt    = span_r;
    growing_nxt = growing_r;
    if (!growing_r) begin
      if (dec <= CW'(1)) begin
        span_nxt    = CW'(1);
        growing_nxt = 1'b1;
      end else begin
        span_nxt = dec;
      end
    end else if (wrap) begin
      span_nxt    = CMAX;
      growing_nxt = 1'b0;
    end else begin
      span_nxt = inc[CW-1:0];
    end
  end

  // Animation state and row scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      span_r    <= CMAX;
      growing_r <= 1'b0;
      corner_r  <= '0;
      x_r       <= '0;
      y_r       <= '0;
    end else begin
      case (ctrl.op)
        OP_INIT: begin
          started_r <= 1'b1;
          span_r    <= CMAX;
          growing_r <= 1'b0;
          corner_r  <= '0;
          x_r       <= '0;
          y_r       <= '0;
        end
        OP_ROW: begin
          if (load) begin
            if (y_r == CMAX) begin
              y_r <= '0;
              x_r <= row_last ? '0 : x_r + 1'b1;
            end else begin
              y_r <= y_r + 1'b1;
            end
          end
        end
        OP_UPDATE: begin
          span_r    <= span_nxt;
          growing_r <= growing_nxt;
        end
        OP_NEWCORNER: corner_r <= corner_r + 1'b1;
        default:      ;
      endcase
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (load) begin
      row_x_r <= COORD_W'(x_r);
      row_y_r <= COORD_W'(y_r);
      mask_r  <= mask;
      rgb_r   <= (mask != '0) ? edge_color : '0;
      end_r   <= row_last;
    end
  end

  assign started       = started_r;
  assign out_valid     = out_valid_r;
  assign out_row_x     = row_x_r;
  assign out_row_y     = row_y_r;
  assign out_lit_mask  = mask_r;
  assign out_red       = rgb_r[23:16];
  assign out_green     = rgb_r[15:8];
  assign out_blue      = rgb_r[7:0];
  assign out_frame_end = end_r;

endmodule

@@ hdl/wbva_checker.sv @@
// ----------------------------------------------------------------------------
// Wireframe box voxel animator: port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "wireframe_box_voxel_animator_macros.svh"

module wbva_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_frame_end,
  input logic [2:0] out_row_x,
  input logic [2:0] out_row_y,
  input logic [7:0] out_lit_mask,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue
);

  // A stalled row stays offered
  `WBVA_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "row dropped under stall")

  // Rows only start while a frame is in progress
  `WBVA_ASSERT(a_rows_busy, $rose(out_valid) |-> in_stall, "row offered while idle")

  // A row right after the last row of a frame starts the next frame at the origin
  `WBVA_ASSERT(a_end_gap, out_valid && !out_stall && out_frame_end |=> !out_valid || ((out_row_x == 3'd0) && (out_row_y == 3'd0)), "next frame not at origin")

  // Dark rows carry no color
  `WBVA_ASSERT(a_dark_row, out_valid && (out_lit_mask == 8'h00) |-> (out_red == 8'h00) && (out_green == 8'h00) && (out_blue == 8'h00), "color on unlit row")

  // Reset empties the output register
  `WBVA_ASSERT_RST(a_reset_out, !rst_n |=> !out_valid, "row valid after reset")

endmodule

bind wireframe_box_voxel_animator wbva_checker u_wbva_checker (.*);

@@ tb/wireframe_box_voxel_animator_test.sv @@
// ----------------------------------------------------------------------------
// Wireframe box voxel animator: testbench
// Sends frame ticks (plus some zero ticks) with random gaps and output stalls.
// A class tracks span, direction, corner and the LCG color sequence, renders
// each expected 64-row frame and checks every row transaction in order.
// ----------------------------------------------------------------------------
module wireframe_box_voxel_animator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wbva_pkg::*;

  localparam int QUIET_LIMIT = 4000;  // cycles without any transaction
  localparam int DRAIN_WAIT  = 300;   // covers a full color draw plus frame update
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [2:0] x;
    logic [2:0] y;
    logic [7:0] mask;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       fend;
  } voxel_row_t;

  // Frame renderer and row checker
  class box_frame_board;
    logic [31:0] seed_reg;
    logic [31:0] lcg;
    bit          started;
    bit          growing;
    int          span;
    int          corner;
    logic [23:0] edge_color;
    logic [23:0] prev_color;
    voxel_row_t  rows_due[$];
    int          bad_rows;
    int          rows_ok;
    int          frames;
    int          zero_ticks;
    int          corner_moves;

    function new();
      seed_reg   = '0;
      lcg        = '0;
      started    = 0;
      growing    = 0;
      span       = CUBE_SIDE - 1;
      corner     = 0;
      edge_color = '0;
      prev_color = WHITE;
    endfunction

    function void load_seed(logic [31:0] v);
      seed_reg = v;
    endfunction

    function logic [7:0] lcg_byte();
      lcg = lcg * LCG_MUL + LCG_INC;
      return lcg[31:24];
    endfunction

    function logic [23:0] roll_color();
      logic [7:0] hi, mid, lo, sel;
      hi  = HI_BASE + lcg_byte() % HI_DIV;
      mid = MID_BASE + lcg_byte() % MID_DIV;
      lo  = lcg_byte() % LO_DIV;
      sel = lcg_byte() % SEL_DIV;
      case (sel)
        8'd0:    return {hi, mid, lo};
        8'd1:    return {hi, lo, mid};
        8'd2:    return {mid, hi, lo};
        8'd3:    return {lo, hi, mid};
        8'd4:    return {mid, lo, hi};
        default: return {lo, mid, hi};
      endcase
    endfunction

    // Up to COLOR_TRIES tries for a new color, then one unconditional draw
    function logic [23:0] fresh_color();
      logic [23:0] c;
      for (int k = 0; k < COLOR_TRIES; k++) begin
        c = roll_color();
        if (c != prev_color) return c;
      end
      return roll_color();
    endfunction

    function void render_frame();
      int m, x0, x1, y0, y1, z0, z1, q;
      bit hx, hy, hz, in_xy;
      voxel_row_t r;
      m  = CUBE_SIDE - 1;
      hx = (corner % 4 == 1) || (corner % 4 == 2);
      hy = (corner % 4 == 2) || (corner % 4 == 3);
      hz = corner >= 4;
      x0 = hx ? m - span : 0;  x1 = hx ? m : span;
      y0 = hy ? m - span : 0;  y1 = hy ? m : span;
      z0 = hz ? m - span : 0;  z1 = hz ? m : span;
      for (int x = 0; x < CUBE_SIDE; x++) begin
        for (int y = 0; y < CUBE_SIDE; y++) begin
          r      = '0;
          r.x    = 3'(x);
          r.y    = 3'(y);
          in_xy  = x >= x0 && x <= x1 && y >= y0 && y <= y1;
          for (int z = 0; z < CUBE_SIDE; z++) begin
            if (in_xy && z >= z0 && z <= z1) begin
              q = int'(x == x0 || x == x1) + int'(y == y0 || y == y1) +
                  int'(z == z0 || z == z1);
              if (q >= 2) r.mask[z] = 1'b1;
            end
          end
          if (r.mask != 0) {r.red, r.green, r.blue} = edge_color;
          r.fend = (x == m) && (y == m);
          rows_due.push_back(r);
        end
      end
    endfunction

    // Accepted input transaction
    function void take_tick(bit tick);
      if (!tick) begin
        zero_ticks++;
        return;
      end
      if (!started) begin
        lcg        = seed_reg;
        span       = CUBE_SIDE - 1;
        growing    = 0;
        corner     = 0;
        prev_color = WHITE;
        edge_color = fresh_color();
        started    = 1;
      end
      render_frame();
      frames++;
      // step span; a finished grow phase moves to the next corner
      if (!growing) begin
        span = (span > 0) ? span - 1 : 0;
        if (span <= 1) begin
          span    = 1;
          growing = 1;
        end
      end else begin
        span++;
        if (span >= CUBE_SIDE - 1) begin
          span       = CUBE_SIDE - 1;
          growing    = 0;
          prev_color = edge_color;
          edge_color = fresh_color();
          corner     = (corner + 1) % 8;
          corner_moves++;
        end
      end
    endfunction

    // Accepted result transaction
    function void check_row(voxel_row_t got);
      voxel_row_t want;
      if (rows_due.size() == 0) begin
        bad_rows++;
        if (bad_rows <= MAX_REPORTS)
          $display("unexpected row x=%0d y=%0d mask=%02h", got.x, got.y, got.mask);
        return;
      end
      want = rows_due.pop_front();
      if (got.x != want.x || got.y != want.y || got.mask != want.mask ||
          got.red != want.red || got.green != want.green ||
          got.blue != want.blue || got.fend != want.fend) begin
        bad_rows++;
        if (bad_rows <= MAX_REPORTS) begin
          $display("row mismatch in frame %0d", frames);
          $display("  expected x=%0d y=%0d mask=%02h rgb=%02h%02h%02h end=%0d",
                   want.x, want.y, want.mask, want.red, want.green, want.blue, want.fend);
          $display("  actual   x=%0d y=%0d mask=%02h rgb=%02h%02h%02h end=%0d",
                   got.x, got.y, got.mask, got.red, got.green, got.blue, got.fend);
        end
      end else begin
        rows_ok++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_tick;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_row_x;
  logic [2:0]  out_row_y;
  logic [7:0]  out_lit_mask;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        out_frame_end;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_seed;

  box_frame_board board = new();
  bit             calm;
  int             quiet;

  wireframe_box_voxel_animator u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_tick       (in_tick),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_row_x     (out_row_x),
    .out_row_y     (out_row_y),
    .out_lit_mask  (out_lit_mask),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_frame_end (out_frame_end),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_seed      (cfg_seed)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 100);
  endfunction

  task automatic send_tick(input bit tick, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_tick  <= tick;
    do @(posedge clk); while (in_stall);
    board.take_tick(tick);
  endtask

  task automatic write_seed(input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_seed  <= v;
    do @(posedge clk); while (!cfg_ready);
    board.load_seed(v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every expected row, then let any trailing draw finish
  task automatic settle();
    while (board.rows_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Output stall pattern
  initial begin
    int run;
    out_stall = 1'b0;
    forever begin
      if (calm) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        run = $urandom_range(1, 30);
        out_stall <= 1'b0;
        repeat (run) @(posedge clk);
        out_stall <= 1'b1;
        repeat (pick_gap() + 1) @(posedge clk);
      end
    end
  end

  // Row monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_row('{x: out_row_x, y: out_row_y, mask: out_lit_mask, red: out_red,
                        green: out_green, blue: out_blue, fend: out_frame_end});
  end

  // Watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet = quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
        $display("wireframe_box_voxel_animator_test: FAIL");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    int          sent;
    bit          tick;
    logic [31:0] first_seed;
    in_valid  = 1'b0;
    in_tick   = 1'b0;
    cfg_valid = 1'b0;
    cfg_seed  = '0;
    calm      = 1'b0;
    quiet     = 0;
    rst_n     = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // seed extremes first, the last write before the first tick is loaded
    write_seed(32'hFFFF_FFFF);
    write_seed(32'h0000_0000);
    case ($urandom_range(0, 2))
      0:       first_seed = 32'h0000_0000;
      1:       first_seed = 32'hFFFF_FFFF;
      default: first_seed = $urandom;
    endcase
    write_seed(first_seed);

    // directed: zero tick before start, first tick, zero tick mid-run,
    // then a full shrink/grow cycle into the next corner
    send_tick(1'b0, 0);
    send_tick(1'b1, 0);
    send_tick(1'b0, 1);
    repeat (13) send_tick(1'b1, $urandom_range(0, 2));
    send_tick(1'b0, 0);
    send_tick(1'b1, 0);
    in_valid <= 1'b0;
    settle();
    // seed written after start must not change anything
    write_seed($urandom);

    // random phases, seed rewritten in between
    for (int p = 0; p < 4; p++) begin
      sent = 0;
      while (sent < 46) begin
        if (sent % 10 == 0) calm = ($urandom_range(0, 3) == 0);
        tick = ($urandom_range(0, 9) != 0);
        send_tick(tick, calm ? 0 : pick_gap());
        if (tick) sent++;
      end
      in_valid <= 1'b0;
      calm = 1'b0;
      settle();
      case (p)
        0:       write_seed(32'hFFFF_FFFF);
        1:       write_seed(32'h0000_0000);
        default: write_seed($urandom);
      endcase
    end

    $display("covered %0d frames and %0d zero ticks, first seed %08h",
             board.frames, board.zero_ticks, first_seed);
    $display("checked %0d rows, %0d corner moves, %0d bad rows",
             board.rows_ok, board.corner_moves, board.bad_rows);
    if (board.bad_rows == 0 && board.rows_due.size() == 0) begin
      $display("wireframe_box_voxel_animator_test: PASS");
    end else begin
      $display("wireframe_box_voxel_animator_test: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/wbva_pkg.sv
hdl/wbva_seq.sv
hdl/wbva_color.sv
hdl/wbva_frame.sv
hdl/wireframe_box_voxel_animator.sv
hdl/wbva_checker.sv
tb/wireframe_box_voxel_animator_test.sv
